/* src/mwf_pkg.sv */
// ----------------------------------------------------------------------------
// mwf_pkg: shared types and codes for the maze wall follower
// Cell codes, operation codes, headings, register indexes, the walker
// state type and the command bundle that goes to the cell memory.
// ----------------------------------------------------------------------------
package mwf_pkg;

    // cell contents
    localparam logic [1:0] CELL_OPEN = 2'd0;
    localparam logic [1:0] CELL_WALL = 2'd1;
    localparam logic [1:0] CELL_MARK = 2'd2;

    // item operations
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // headings
    localparam logic [1:0] HEAD_DOWN  = 2'd0;
    localparam logic [1:0] HEAD_LEFT  = 2'd1;
    localparam logic [1:0] HEAD_UP    = 2'd2;
    localparam logic [1:0] HEAD_RIGHT = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_START_ROW  = 2'd0;
    localparam logic [1:0] CFG_START_COL  = 2'd1;
    localparam logic [1:0] CFG_FINISH_ROW = 2'd2;
    localparam logic [1:0] CFG_FINISH_COL = 2'd3;

    // configuration reset values
    localparam logic [3:0] RST_START_ROW  = 4'd0;
    localparam logic [3:0] RST_START_COL  = 4'd5;
    localparam logic [3:0] RST_FINISH_ROW = 4'd11;
    localparam logic [3:0] RST_FINISH_COL = 4'd5;

    // candidate headings are tried in this order
    localparam logic [1:0] TRY_TURN_PLUS  = 2'd0;
    localparam logic [1:0] TRY_STRAIGHT   = 2'd1;
    localparam logic [1:0] TRY_TURN_MINUS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AHEAD_CHK,
        ST_MARK,
        ST_TURN_CHK,
        ST_DONE
    } t_walk_state;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic [1:0] wr_data;
    } t_ram_cmd;

endpackage

/* src/mwf_cell_ram.sv */
// ----------------------------------------------------------------------------
// mwf_cell_ram: maze cell memory
// One write port and one read port with registered read data. After reset a
// sweep writes every entry open, one per cycle, while o_clr_busy is high.
// ----------------------------------------------------------------------------
module mwf_cell_ram #(
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mwf_pkg::t_ram_cmd i_cmd,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    output logic [1:0]        o_rd_data,
    output logic              o_clr_busy
);

    localparam int DEPTH = 1 << AW;

    logic [1:0]    mem [DEPTH];
    logic [1:0]    r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= mwf_pkg::CELL_OPEN;
        end else if (i_cmd.wr_en) begin
            mem[i_wr_addr] <= i_cmd.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

`ifndef NO_ASSERTIONS
    a_no_access_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_cmd.wr_en && !i_cmd.rd_en)
        else $error("cell memory accessed during clearing sweep");

    a_clear_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy && r_clr_addr != {AW{1'b1}} |=> r_clr_busy &&
            r_clr_addr == $past(r_clr_addr) + 1'b1)
        else $error("clearing sweep skipped an entry");
`endif

endmodule

/* src/mwf_walker.sv */
// ----------------------------------------------------------------------------
// mwf_walker: item sequencer and walker state
// Takes one item at a time, drives the cell memory through read, check and
// write-back steps, and holds the walker position and heading.
// ----------------------------------------------------------------------------
module mwf_walker #(
    parameter int MAZE_ROWS = 16,
    parameter int MAZE_COLS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_operation,
    input  logic [3:0]          i_cell_row,
    input  logic [3:0]          i_cell_col,
    input  logic [1:0]          i_cell_kind,
    input  logic [3:0]          i_start_row,
    input  logic [3:0]          i_start_col,
    input  logic [3:0]          i_finish_row,
    input  logic [3:0]          i_finish_col,
    input  logic                i_clr_busy,
    input  logic [1:0]          i_rd_data,
    output mwf_pkg::t_ram_cmd   o_cmd,
    output logic [$clog2(MAZE_ROWS)+$clog2(MAZE_COLS)-1:0] o_rd_addr,
    output logic [$clog2(MAZE_ROWS)+$clog2(MAZE_COLS)-1:0] o_wr_addr,
    input  logic                i_out_free,
    output logic                o_done,
    output logic [3:0]          o_row,
    output logic [3:0]          o_col,
    output logic [1:0]          o_head,
    output logic                o_at_goal
);

    localparam int RAW  = $clog2(MAZE_ROWS);
    localparam int CAW  = $clog2(MAZE_COLS);
    localparam int AW   = RAW + CAW;
    localparam int MAXW = (RAW > CAW) ? RAW : CAW;
    localparam int PW   = (MAXW > 4) ? MAXW : 4;
    localparam logic [PW:0] ROWS_W = (PW+1)'(MAZE_ROWS);
    localparam logic [PW:0] COLS_W = (PW+1)'(MAZE_COLS);

    mwf_pkg::t_walk_state r_state, n_state;
    logic [PW-1:0] r_row, n_row;
    logic [PW-1:0] r_col, n_col;
    logic [1:0]    r_head, n_head;
    logic [1:0]    r_try, n_try;
    logic [PW-1:0] r_nr, n_nr;
    logic [PW-1:0] r_nc, n_nc;
    logic          r_rd_off, n_rd_off;

    logic          accept;
    logic          at_goal;
    logic          cur_on_grid;
    logic          load_on_grid;
    logic          kind_ok;
    logic [PW-1:0] load_row;
    logic [PW-1:0] load_col;
    logic [2*PW:0] ahead_nb;
    logic [2*PW:0] try_nb;
    logic [PW-1:0] base_row;
    logic [PW-1:0] base_col;
    logic [1:0]    issue_try;
    logic          cell_open;

    // neighbor in heading h: {on grid, row, col}
    function automatic logic [2*PW:0] nb_calc(input logic [PW-1:0] row,
                                              input logic [PW-1:0] col,
                                              input logic [1:0]    h);
        logic [PW:0] r;
        logic [PW:0] c;
        logic        under;
        begin
            r     = {1'b0, row};
            c     = {1'b0, col};
            under = 1'b0;
            case (h)
                mwf_pkg::HEAD_DOWN: r = r + 1'b1;
                mwf_pkg::HEAD_LEFT: begin
                    under = (col == '0);
                    c     = c - 1'b1;
                end
                mwf_pkg::HEAD_UP: begin
                    under = (row == '0);
                    r     = r - 1'b1;
                end
                mwf_pkg::HEAD_RIGHT: c = c + 1'b1;
                default: under = 1'b1;
            endcase
            return {(!under && (r < ROWS_W) && (c < COLS_W)), r[PW-1:0], c[PW-1:0]};
        end
    endfunction

    function automatic logic [1:0] try_heading(input logic [1:0] h, input logic [1:0] k);
        begin
            case (k)
                mwf_pkg::TRY_TURN_PLUS: return h + 2'd1;
                mwf_pkg::TRY_STRAIGHT:  return h;
                default:                return h + 2'd3;
            endcase
        end
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] row,
                                              input logic [PW-1:0] col);
        begin
            return {row[RAW-1:0], col[CAW-1:0]};
        end
    endfunction

    assign o_in_stall   = (r_state != mwf_pkg::ST_IDLE) || i_clr_busy;
    assign accept       = i_in_valid && !o_in_stall;
    assign at_goal      = (r_row == PW'(i_finish_row)) && (r_col == PW'(i_finish_col));
    assign cur_on_grid  = ({1'b0, r_row} < ROWS_W) && ({1'b0, r_col} < COLS_W);
    assign load_row     = PW'(i_cell_row);
    assign load_col     = PW'(i_cell_col);
    assign load_on_grid = ({1'b0, load_row} < ROWS_W) && ({1'b0, load_col} < COLS_W);
    assign kind_ok      = (i_cell_kind == mwf_pkg::CELL_OPEN) ||
                          (i_cell_kind == mwf_pkg::CELL_WALL) ||
                          (i_cell_kind == mwf_pkg::CELL_MARK);

    // tries start from the new cell while the mark is being written
    assign base_row  = (r_state == mwf_pkg::ST_MARK) ? r_nr : r_row;
    assign base_col  = (r_state == mwf_pkg::ST_MARK) ? r_nc : r_col;
    assign issue_try = (r_state == mwf_pkg::ST_TURN_CHK) ? r_try + 2'd1
                                                         : mwf_pkg::TRY_TURN_PLUS;
    assign ahead_nb  = nb_calc(r_row, r_col, r_head);
    assign try_nb    = nb_calc(base_row, base_col, try_heading(r_head, issue_try));
    assign cell_open = !r_rd_off && (i_rd_data != mwf_pkg::CELL_WALL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mwf_pkg::ST_IDLE;
            r_row    <= '0;
            r_col    <= PW'(5);
            r_head   <= mwf_pkg::HEAD_DOWN;
            r_try    <= mwf_pkg::TRY_TURN_PLUS;
            r_rd_off <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_head   <= n_head;
            r_try    <= n_try;
            r_rd_off <= n_rd_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nr <= n_nr;
        r_nc <= n_nc;
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_head    = r_head;
        n_try     = r_try;
        n_nr      = r_nr;
        n_nc      = r_nc;
        n_rd_off  = r_rd_off;
        o_cmd     = '0;
        o_rd_addr = addr_of(try_nb[2*PW-1:PW], try_nb[PW-1:0]);
        o_wr_addr = addr_of(r_nr, r_nc);
        case (r_state)
            mwf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = mwf_pkg::ST_DONE;
                    case (i_operation)
                        mwf_pkg::OP_LOAD: begin
                            o_cmd.wr_en   = load_on_grid && kind_ok;
                            o_cmd.wr_data = i_cell_kind;
                            o_wr_addr     = addr_of(load_row, load_col);
                        end
                        mwf_pkg::OP_STEP: begin
                            if (!at_goal) begin
                                if (ahead_nb[2*PW]) begin
                                    o_cmd.rd_en = 1'b1;
                                    o_rd_addr   = addr_of(ahead_nb[2*PW-1:PW],
                                                          ahead_nb[PW-1:0]);
                                    n_nr        = ahead_nb[2*PW-1:PW];
                                    n_nc        = ahead_nb[PW-1:0];
                                    n_state     = mwf_pkg::ST_AHEAD_CHK;
                                end else begin
                                    // no move: go straight to the heading choice
                                    o_cmd.rd_en = try_nb[2*PW];
                                    n_rd_off    = !try_nb[2*PW];
                                    n_try       = mwf_pkg::TRY_TURN_PLUS;
                                    n_state     = mwf_pkg::ST_TURN_CHK;
                                end
                            end
                        end
                        mwf_pkg::OP_RESTART: begin
                            n_row  = PW'(i_start_row);
                            n_col  = PW'(i_start_col);
                            n_head = mwf_pkg::HEAD_DOWN;
                        end
                        default: ;
                    endcase
                end
            end
            mwf_pkg::ST_AHEAD_CHK: begin
                // erase the backtrack before stepping onto a marked cell
                o_cmd.wr_en   = (i_rd_data == mwf_pkg::CELL_MARK) && cur_on_grid;
                o_cmd.wr_data = mwf_pkg::CELL_OPEN;
                o_wr_addr     = addr_of(r_row, r_col);
                n_state       = mwf_pkg::ST_MARK;
            end
            mwf_pkg::ST_MARK: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_data = mwf_pkg::CELL_MARK;
                n_row         = r_nr;
                n_col         = r_nc;
                o_cmd.rd_en   = try_nb[2*PW];
                n_rd_off      = !try_nb[2*PW];
                n_try         = mwf_pkg::TRY_TURN_PLUS;
                n_state       = mwf_pkg::ST_TURN_CHK;
            end
            mwf_pkg::ST_TURN_CHK: begin
                if (cell_open) begin
                    n_head  = try_heading(r_head, r_try);
                    n_state = mwf_pkg::ST_DONE;
                end else if (r_try == mwf_pkg::TRY_TURN_MINUS) begin
                    n_head  = r_head + 2'd2;
                    n_state = mwf_pkg::ST_DONE;
                end else begin
                    o_cmd.rd_en = try_nb[2*PW];
                    n_rd_off    = !try_nb[2*PW];
                    n_try       = issue_try;
                end
            end
            mwf_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = mwf_pkg::ST_IDLE;
                end
            end
            default: n_state = mwf_pkg::ST_IDLE;
        endcase
    end

    assign o_done    = (r_state == mwf_pkg::ST_DONE);
    assign o_row     = r_row[3:0];
    assign o_col     = r_col[3:0];
    assign o_head    = r_head;
    assign o_at_goal = at_goal;

`ifndef NO_ASSERTIONS
    a_try_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mwf_pkg::ST_TURN_CHK |-> r_try != 2'd3)
        else $error("heading try index out of range");

    a_mark_on_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mwf_pkg::ST_MARK |-> ({1'b0, r_nr} < ROWS_W) && ({1'b0, r_nc} < COLS_W))
        else $error("mark written off the grid");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mwf_pkg::ST_DONE && !i_out_free |=> r_state == mwf_pkg::ST_DONE)
        else $error("result dropped while output slot was full");

    a_head_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_head) |->
            $past(r_state) == mwf_pkg::ST_TURN_CHK || $past(r_state) == mwf_pkg::ST_IDLE)
        else $error("heading changed outside turn choice or restart");
`endif

endmodule

/* src/maze_wall_follower_core.sv */
// ----------------------------------------------------------------------------
// maze_wall_follower_core: maze grid store with a wall-following walker
// Configuration registers, result register and the walker with its memory.
// ----------------------------------------------------------------------------
// One item is taken at a time. Load, restart, an unused operation and a step
// on the finish cell go from accept straight to the result state; a step that
// moves passes the ahead check, mark and turn-choice states, and a step
// blocked by the grid edge goes straight to the turn choice. The cell memory
// has a single read port with registered read data: the cell ahead is read
// and checked, the old cell is unmarked if the cell ahead was marked and the
// new one marked on the write port, then the candidate headings are read one
// per cycle. After reset the memory is swept open with input stall high;
// configuration writes are taken during the sweep. A finished result sits in
// an output register, so the next item is accepted while it waits.
module maze_wall_follower_core #(
    parameter int MAZE_ROWS = 16,
    parameter int MAZE_COLS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [3:0] i_cell_row,
    input  logic [3:0] i_cell_col,
    input  logic [1:0] i_cell_kind,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_walker_row,
    output logic [3:0] o_walker_col,
    output logic [1:0] o_heading,
    output logic       o_at_finish
);

    localparam int AW = $clog2(MAZE_ROWS) + $clog2(MAZE_COLS);

    logic [3:0] r_start_row;
    logic [3:0] r_start_col;
    logic [3:0] r_finish_row;
    logic [3:0] r_finish_col;

    logic       r_out_valid;
    logic [3:0] r_out_row;
    logic [3:0] r_out_col;
    logic [1:0] r_out_head;
    logic       r_out_finish;

    mwf_pkg::t_ram_cmd ram_cmd;
    logic [AW-1:0]     ram_rd_addr;
    logic [AW-1:0]     ram_wr_addr;
    logic [1:0]        ram_rd_data;
    logic              clr_busy;
    logic              out_free;
    logic              w_done;
    logic [3:0]        w_row;
    logic [3:0]        w_col;
    logic [1:0]        w_head;
    logic              w_at_goal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row  <= mwf_pkg::RST_START_ROW;
            r_start_col  <= mwf_pkg::RST_START_COL;
            r_finish_row <= mwf_pkg::RST_FINISH_ROW;
            r_finish_col <= mwf_pkg::RST_FINISH_COL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mwf_pkg::CFG_START_ROW:  r_start_row  <= i_cfg_data;
                mwf_pkg::CFG_START_COL:  r_start_col  <= i_cfg_data;
                mwf_pkg::CFG_FINISH_ROW: r_finish_row <= i_cfg_data;
                mwf_pkg::CFG_FINISH_COL: r_finish_col <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // load the result beat only when the slot is free
    always_ff @(posedge i_clk) begin
        if (w_done && out_free) begin
            r_out_row    <= w_row;
            r_out_col    <= w_col;
            r_out_head   <= w_head;
            r_out_finish <= w_at_goal;
        end
    end

    mwf_walker #(
        .MAZE_ROWS (MAZE_ROWS),
        .MAZE_COLS (MAZE_COLS)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_cell_row   (i_cell_row),
        .i_cell_col   (i_cell_col),
        .i_cell_kind  (i_cell_kind),
        .i_start_row  (r_start_row),
        .i_start_col  (r_start_col),
        .i_finish_row (r_finish_row),
        .i_finish_col (r_finish_col),
        .i_clr_busy   (clr_busy),
        .i_rd_data    (ram_rd_data),
        .o_cmd        (ram_cmd),
        .o_rd_addr    (ram_rd_addr),
        .o_wr_addr    (ram_wr_addr),
        .i_out_free   (out_free),
        .o_done       (w_done),
        .o_row        (w_row),
        .o_col        (w_col),
        .o_head       (w_head),
        .o_at_goal    (w_at_goal)
    );

    mwf_cell_ram #(
        .AW (AW)
    ) u_cell_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ram_cmd),
        .i_rd_addr  (ram_rd_addr),
        .i_wr_addr  (ram_wr_addr),
        .o_rd_data  (ram_rd_data),
        .o_clr_busy (clr_busy)
    );

    assign o_out_valid  = r_out_valid;
    assign o_walker_row = r_out_row;
    assign o_walker_col = r_out_col;
    assign o_heading    = r_out_head;
    assign o_at_finish  = r_out_finish;

endmodule
